// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the deframer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DTMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define DTMD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) else $error(msg);

`endif

// ----- rtl/core/dtmd_pkg.sv -----
// Types and constants for the dot-terminated message deframer.
// No dependencies; used by every module and interface of the block.
package dtmd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LF,
    PH_LFDOT,
    PH_LFDOTCR
  } phase_e;

  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrDot = 8'h2E;

  // at most four results per input byte
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;
  localparam int unsigned NumCand = 5;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [CntW-1:0]             cnt;
    out_word_t [MaxRes-1:0]      word;
  } push_t;

endpackage

// ----- rtl/core/dtmd_if.sv -----
// Valid/ready channel interfaces for the deframer input and output words.
// Depends on dtmd_pkg for the payload types.
interface dtmd_in_if;
  logic               valid;
  logic               ready;
  dtmd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dtmd_out_if;
  logic                valid;
  logic                ready;
  dtmd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dtmd_parse.sv -----
// Input register, terminator match state machine and result packing.
// Depends on dtmd_pkg and dtmd_in_if.
module dtmd_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  dtmd_in_if.sink            in_i,
  input  logic               room_i,
  output dtmd_pkg::push_t    push_o
);

  logic                 vld_q;
  logic [7:0]           byte_q;
  dtmd_pkg::phase_e     phase_q, phase_d;
  logic                 hcr_q, hcr_d;
  logic                 advance;

  logic                 pre_cr, pre_lf, pre_end, run_idle, hcr_eff;
  logic [dtmd_pkg::NumCand-1:0] cand_en;
  dtmd_pkg::out_word_t [dtmd_pkg::NumCand-1:0] cand;
  dtmd_pkg::out_word_t [dtmd_pkg::MaxRes-1:0]  words;
  logic [dtmd_pkg::CntW-1:0] n;

  assign advance    = vld_q & room_i;
  assign in_i.ready = ~vld_q | room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= dtmd_pkg::PH_IDLE;
      hcr_q   <= 1'b0;
    end else begin
      if (in_i.ready) vld_q <= in_i.valid;
      if (advance) begin
        phase_q <= phase_d;
        hcr_q   <= hcr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) byte_q <= in_i.data.data_byte;
  end

  // output decode: held bytes released ahead of the idle handling of byte_q
  always_comb begin
    pre_cr   = 1'b0;
    pre_lf   = 1'b0;
    pre_end  = 1'b0;
    run_idle = 1'b0;
    hcr_eff  = hcr_q;
    unique case (phase_q)
      dtmd_pkg::PH_LF: begin
        if (byte_q != dtmd_pkg::ChrDot) begin
          pre_cr   = hcr_q;
          pre_lf   = 1'b1;
          run_idle = 1'b1;
          hcr_eff  = 1'b0;
        end
      end
      dtmd_pkg::PH_LFDOT: begin
        if (byte_q == dtmd_pkg::ChrLf) begin
          pre_cr  = hcr_q;
          pre_end = 1'b1;
        end else if (!(byte_q == dtmd_pkg::ChrCr && hcr_q)) begin
          pre_cr   = hcr_q;
          pre_lf   = 1'b1;
          run_idle = 1'b1;
          hcr_eff  = 1'b0;
        end
      end
      dtmd_pkg::PH_LFDOTCR: begin
        if (byte_q == dtmd_pkg::ChrLf) begin
          pre_end = 1'b1;
        end else begin
          pre_cr   = 1'b1;
          pre_lf   = 1'b1;
          run_idle = 1'b1;
          hcr_eff  = 1'b1;
        end
      end
      dtmd_pkg::PH_IDLE: begin
        run_idle = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    hcr_d   = hcr_q;
    unique case (phase_q)
      dtmd_pkg::PH_LF: begin
        if (byte_q == dtmd_pkg::ChrDot) phase_d = dtmd_pkg::PH_LFDOT;
      end
      dtmd_pkg::PH_LFDOT: begin
        if (byte_q == dtmd_pkg::ChrLf) begin
          phase_d = dtmd_pkg::PH_IDLE;
          hcr_d   = 1'b0;
        end else if (byte_q == dtmd_pkg::ChrCr && hcr_q) begin
          phase_d = dtmd_pkg::PH_LFDOTCR;
        end
      end
      dtmd_pkg::PH_LFDOTCR: begin
        if (byte_q == dtmd_pkg::ChrLf) begin
          phase_d = dtmd_pkg::PH_IDLE;
          hcr_d   = 1'b0;
        end
      end
      dtmd_pkg::PH_IDLE: begin
        phase_d = dtmd_pkg::PH_IDLE;
      end
    endcase
    if (run_idle) begin
      if (byte_q == dtmd_pkg::ChrLf) begin
        phase_d = dtmd_pkg::PH_LF;
        hcr_d   = hcr_eff;
      end else if (byte_q == dtmd_pkg::ChrCr) begin
        phase_d = dtmd_pkg::PH_IDLE;
        hcr_d   = 1'b1;
      end else begin
        phase_d = dtmd_pkg::PH_IDLE;
        hcr_d   = 1'b0;
      end
    end
  end

  // candidate results in release order
  always_comb begin
    cand_en[0] = pre_cr;
    cand_en[1] = pre_lf;
    cand_en[2] = pre_end;
    cand_en[3] = run_idle & hcr_eff & (byte_q != dtmd_pkg::ChrLf);
    cand_en[4] = run_idle & (byte_q != dtmd_pkg::ChrLf) & (byte_q != dtmd_pkg::ChrCr);
    cand[0] = '{out_byte: dtmd_pkg::ChrCr, byte_valid: 1'b1, message_end: 1'b0, last: 1'b0};
    cand[1] = '{out_byte: dtmd_pkg::ChrLf, byte_valid: 1'b1, message_end: 1'b0, last: 1'b0};
    cand[2] = '{out_byte: 8'h00, byte_valid: 1'b0, message_end: 1'b1, last: 1'b0};
    cand[3] = '{out_byte: dtmd_pkg::ChrCr, byte_valid: 1'b1, message_end: 1'b0, last: 1'b0};
    cand[4] = '{out_byte: byte_q, byte_valid: 1'b1, message_end: 1'b0, last: 1'b0};
  end

  // compact enabled candidates, flag the final one
  always_comb begin
    n     = '0;
    words = '0;
    for (int i = 0; i < dtmd_pkg::NumCand; i++) begin
      if (cand_en[i]) begin
        words[n[1:0]] = cand[i];
        n = n + dtmd_pkg::CntW'(1);
      end
    end
    for (int j = 0; j < dtmd_pkg::MaxRes; j++) begin
      words[j].last = (dtmd_pkg::CntW'(j) == n - dtmd_pkg::CntW'(1));
    end
  end

  assign push_o.cnt  = advance ? n : '0;
  assign push_o.word = words;

endmodule

// ----- rtl/core/dtmd_outq.sv -----
// Result queue: takes up to four result words per cycle, drains one per cycle while out_o.ready is high.
// Depends on dtmd_pkg and dtmd_out_if.
module dtmd_outq #(
  parameter int unsigned Depth = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dtmd_pkg::push_t                  push_i,
  output logic                             room_o,
  output logic [$clog2(Depth+1)-1:0]       level_o,
  dtmd_out_if.source                       out_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned LvlW = $clog2(Depth + 1);
  localparam logic [LvlW-1:0] RoomMax = LvlW'(Depth - dtmd_pkg::MaxRes);
  localparam logic [PtrW:0]   DepthW  = (PtrW + 1)'(Depth);

  dtmd_pkg::out_word_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q, wr_d, rd_d;
  logic [LvlW-1:0] level_q, level_d;
  logic [PtrW-1:0] wr_idx [dtmd_pkg::MaxRes];
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] base, logic [PtrW:0] inc);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + inc;
    if (sum >= DepthW) sum = sum - DepthW;
    return sum[PtrW-1:0];
  endfunction

  assign pop         = out_o.valid & out_o.ready;
  assign out_o.valid = (level_q != '0);
  assign out_o.data  = mem_q[rd_q];
  assign room_o      = (level_q <= RoomMax);
  assign level_o     = level_q;

  always_comb begin
    for (int i = 0; i < dtmd_pkg::MaxRes; i++) begin
      wr_idx[i] = wrap_add(wr_q, (PtrW + 1)'(i));
    end
    wr_d    = wrap_add(wr_q, (PtrW + 1)'(push_i.cnt));
    rd_d    = pop ? wrap_add(rd_q, (PtrW + 1)'(1)) : rd_q;
    level_d = level_q + LvlW'(push_i.cnt) - LvlW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < dtmd_pkg::MaxRes; i++) begin
      if (dtmd_pkg::CntW'(i) < push_i.cnt) mem_q[wr_idx[i]] <= push_i.word[i];
    end
  end

endmodule

// ----- rtl/core/dot_terminated_message_deframer.sv -----
// Top level of the dot-terminated message deframer.
// Depends on dtmd_pkg, dtmd_if, dtmd_parse, dtmd_outq and assert_macros.svh.
//
// Byte stream in, message words out. A message ends at CR LF '.' CR LF or
// LF '.' LF, whichever completes first. The end is signaled by a word with
// message_end set and byte_valid clear. A '.' right after an LF inside a
// message is dropped. Bytes that could open a terminator are held and come
// out once the match fails, so one input byte yields zero to four words.
// last marks the final word caused by a byte. A byte leaves the input
// register when the result queue holds at most QueueDepth - 4 words. A new
// byte is accepted whenever the input register is empty or its byte leaves
// in the same cycle. The output drains one word per cycle while the receiver
// is ready, so the sustained input rate is one byte per cycle as long as
// bytes average at most one word each. A byte passes through the input
// register, and its words through the result queue, on the way to the output.
`include "assert_macros.svh"

module dot_terminated_message_deframer #(
  parameter int unsigned QueueDepth = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtmd_in_if.sink     in_i,
  dtmd_out_if.source  out_o
);

  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  dtmd_pkg::push_t  push;
  logic             room;
  logic [LvlW-1:0]  level;
  logic             out_end, end_ok, out_gap, level_idle;

  dtmd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  dtmd_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .level_o (level),
    .out_o   (out_o)
  );

  assign out_end    = out_o.valid & out_o.data.message_end;
  assign end_ok     = ~out_o.data.byte_valid & out_o.data.last;
  assign out_gap    = out_o.valid & ~out_o.data.byte_valid;
  assign level_idle = (push.cnt == '0) & ~(out_o.valid & out_o.ready);

  `DTMD_NEVER(a_level_bound, clk_i, rst_ni, level > LvlW'(QueueDepth), "queue overflow")
  `DTMD_ASSERT(a_end_word, clk_i, rst_ni, out_end |-> end_ok, "bad end word")
  `DTMD_ASSERT(a_word_kind, clk_i, rst_ni, out_gap |-> out_o.data.message_end, "empty word")
  `DTMD_ASSERT(a_level_hold, clk_i, rst_ni, level_idle |=> $stable(level), "level drift")

endmodule

// ----- sim/dot_terminated_message_deframer_test.sv -----
`timescale 1ns / 1ps
// Testbench for dot_terminated_message_deframer: feeds raw text bytes, predicts
// the deframed words with a behavioral model and checks every output word.
// Depends on dtmd_pkg, dtmd_if and the deframer RTL.
module dot_terminated_message_deframer_test;
  import dtmd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dtmd_in_if  in_ch ();
  dtmd_out_if out_ch ();

  dot_terminated_message_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0] pending_bytes [$];
  out_word_t  deframed_words [$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count = 0;
  logic       hold_off_go = 1'b0;
  logic       hold_off_done;
  int         hold_off_left;

  // model state
  phase_e     model_phase = PH_IDLE;
  logic       model_held_cr = 1'b0;

  task automatic emit_word(input logic [7:0] b, input logic valid, input logic msg_end);
    out_word_t w;
    w.out_byte    = valid ? b : 8'h00;
    w.byte_valid  = valid;
    w.message_end = msg_end;
    w.last        = 1'b0;
    deframed_words.push_back(w);
  endtask

  task automatic idle_byte(input logic [7:0] c);
    if (c == ChrLf) begin
      model_phase = PH_LF;
    end else if (c == ChrCr) begin
      if (model_held_cr) emit_word(ChrCr, 1'b1, 1'b0);
      model_held_cr = 1'b1;
      model_phase = PH_IDLE;
    end else begin
      if (model_held_cr) emit_word(ChrCr, 1'b1, 1'b0);
      model_held_cr = 1'b0;
      emit_word(c, 1'b1, 1'b0);
      model_phase = PH_IDLE;
    end
  endtask

  // held [CR] LF goes out, a held dot after it is dropped
  task automatic release_line_end();
    if (model_held_cr) emit_word(ChrCr, 1'b1, 1'b0);
    emit_word(ChrLf, 1'b1, 1'b0);
    model_held_cr = 1'b0;
    model_phase = PH_IDLE;
  endtask

  task automatic deframe_byte(input logic [7:0] c);
    int before_cnt;
    before_cnt = deframed_words.size();
    case (model_phase)
      PH_LF: begin
        if (c == ChrDot) begin
          model_phase = PH_LFDOT;
        end else begin
          release_line_end();
          idle_byte(c);
        end
      end
      PH_LFDOT: begin
        if (c == ChrLf) begin
          if (model_held_cr) emit_word(ChrCr, 1'b1, 1'b0);
          emit_word(8'h00, 1'b0, 1'b1);
          model_held_cr = 1'b0;
          model_phase = PH_IDLE;
        end else if (c == ChrCr && model_held_cr) begin
          model_phase = PH_LFDOTCR;
        end else begin
          release_line_end();
          idle_byte(c);
        end
      end
      PH_LFDOTCR: begin
        if (c == ChrLf) begin
          emit_word(8'h00, 1'b0, 1'b1);
          model_held_cr = 1'b0;
          model_phase = PH_IDLE;
        end else begin
          emit_word(ChrCr, 1'b1, 1'b0);
          emit_word(ChrLf, 1'b1, 1'b0);
          model_held_cr = 1'b1;
          model_phase = PH_IDLE;
          idle_byte(c);
        end
      end
      default: begin
        model_phase = PH_IDLE;
        idle_byte(c);
      end
    endcase
    if (deframed_words.size() > before_cnt)
      deframed_words[deframed_words.size() - 1].last = 1'b1;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (deframed_words.size() == 0) begin
      if (mismatch_count < 10)
        $display("%0t: unexpected word byte=%h valid=%b end=%b last=%b",
                 $realtime, got.out_byte, got.byte_valid, got.message_end, got.last);
      mismatch_count++;
    end else begin
      want = deframed_words.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.message_end !== want.message_end || got.last !== want.last) begin
        if (mismatch_count < 10)
          $display("%0t: word mismatch exp byte=%h valid=%b end=%b last=%b",
                   $realtime, want.out_byte, want.byte_valid, want.message_end,
                   want.last, ", got byte=%h valid=%b end=%b last=%b",
                   got.out_byte, got.byte_valid, got.message_end, got.last);
        mismatch_count++;
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.data.data_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid          <= 1'b1;
          in_ch.data.data_byte <= pending_bytes.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, fired once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else if (hold_off_go && !hold_off_done) begin
      hold_off_left <= 300;
      hold_off_done <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word(out_ch.data);
      out_ch.ready <= (hold_off_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return ChrCr;
      1: return ChrLf;
      2: return ChrDot;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_line_end(input logic with_cr);
    if (with_cr) pending_bytes.push_back(ChrCr);
    pending_bytes.push_back(ChrLf);
  endtask

  task automatic queue_message();
    int  lines;
    int  kind;
    lines = $urandom_range(0, 3);
    for (int l = 0; l < lines; l++) begin
      int len;
      len = $urandom_range(0, 6);
      if (l > 0) queue_line_end(1'($urandom_range(1)));
      if ($urandom_range(3) == 0) pending_bytes.push_back(ChrDot);
      for (int k = 0; k < len; k++) pending_bytes.push_back(pick_byte());
    end
    kind = $urandom_range(2);
    queue_line_end(kind != 0);
    pending_bytes.push_back(ChrDot);
    queue_line_end(kind == 1);
  endtask

  task automatic queue_random(input int count);
    int target;
    int noise_len;
    target = pending_bytes.size() + count;
    while (pending_bytes.size() < target) begin
      if ($urandom_range(4) == 0) begin
        noise_len = $urandom_range(1, 4);
        for (int k = 0; k < noise_len; k++) pending_bytes.push_back(pick_byte());
      end else begin
        queue_message();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_ch.valid || deframed_words.size() != 0)
      @(negedge clk_i);
  endtask

  logic [7:0] directed_bytes [25] = '{
    ChrLf, ChrDot, ChrLf,                         // empty message, LF form
    ChrCr, ChrLf, ChrDot, ChrCr, ChrLf,           // empty message, CRLF form
    ChrLf, ChrDot, 8'h78,                         // failed match, dot dropped
    ChrCr, ChrCr, ChrLf, ChrDot, ChrLf,           // LF form after CR
    ChrLf, ChrDot, ChrCr, 8'h00,                  // CR without held CR
    ChrCr, ChrLf, ChrDot, ChrCr, 8'hFF            // broken CRLF form, four words
  };

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // no idling, with one long receiver hold-off
    hold_off_go <= 1'b1;
    foreach (directed_bytes[i]) pending_bytes.push_back(directed_bytes[i]);
    queue_random(55);
    wait_drained();

    send_idle_pct  = 67;
    recv_stall_pct = 0;
    queue_random(60);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 67;
    queue_random(60);
    wait_drained();

    send_idle_pct  = 31;
    recv_stall_pct = 31;
    queue_random(60);
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("dot_terminated_message_deframer_test: PASS");
    end else begin
      $display("dot_terminated_message_deframer_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("dot_terminated_message_deframer_test: FAIL");
    $finish;
  end

endmodule
